// File: hdl/assert_macros.svh
// Assertion helpers for the interrupt status and mask unit.
// Each macro expands to a labeled concurrent assertion clocked on aclk
// and disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ISU_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("isu assertion failed");

`define ISU_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("isu assertion failed");

`else

`define ISU_ASSERT_IMP(label, ante, cons)

`define ISU_ASSERT_NXT(label, ante, cons)

`endif

`endif

// File: hdl/isu_pkg.sv
package isu_pkg;

    localparam int DataW = 16;
    localparam int IdxW = 5;
    localparam int ReqW = 3;
    localparam int BankDepth = 12;
    localparam int SlotW = 4;

    localparam logic [DataW-1:0] Full16 = 16'hFFFF;

    // Request codes
    localparam logic [ReqW-1:0] REQ_READ = 3'd0;
    localparam logic [ReqW-1:0] REQ_WRITE = 3'd1;
    localparam logic [ReqW-1:0] REQ_ASSERT = 3'd2;
    localparam logic [ReqW-1:0] REQ_DEASSERT = 3'd3;
    localparam logic [ReqW-1:0] REQ_QUERY = 3'd4;

    // Bank slots that feed the pending flag and that reset to all ones
    localparam logic [SlotW-1:0] SLOT_SYS1 = 4'd0;
    localparam logic [SlotW-1:0] SLOT_GPIO_LO = 4'd3;
    localparam logic [SlotW-1:0] SLOT_SYS2 = 4'd5;
    localparam logic [SlotW-1:0] SLOT_GPIO_HI = 4'd6;

    typedef enum logic [3:0] {
        K_STATUS,
        K_MASK,
        K_SOFT,
        K_NMI,
        K_ASSIGN2,
        K_ASSIGN3,
        K_ZERO,
        K_ONES,
        K_UNMAPPED
    } reg_kind_t;

    typedef struct packed {
        logic [ReqW-1:0]  req_type;
        logic [IdxW-1:0]  reg_index;
        logic [DataW-1:0] write_data;
        logic [DataW-1:0] source_bits;
    } in_item_t;

    typedef struct packed {
        logic [DataW-1:0] read_data;
        logic             irq_pending;
        logic             bad_index;
    } out_item_t;

    // Register kind in read decoder order
    function automatic reg_kind_t reg_kind_f(input logic [IdxW-1:0] idx);
        reg_kind_t k;
        case (idx)
            5'd0, 5'd1, 5'd3, 5'd4, 5'd5, 5'd16, 5'd17, 5'd18,
            5'd22, 5'd23, 5'd24, 5'd28:                k = K_STATUS;
            5'd6, 5'd7, 5'd9, 5'd10, 5'd11, 5'd19, 5'd20, 5'd21,
            5'd25, 5'd26, 5'd27, 5'd29:                k = K_MASK;
            5'd2, 5'd30:                               k = K_ZERO;
            5'd8:                                      k = K_ONES;
            5'd12:                                     k = K_NMI;
            5'd13:                                     k = K_SOFT;
            5'd14:                                     k = K_ASSIGN2;
            5'd15:                                     k = K_ASSIGN3;
            default:                                   k = K_UNMAPPED;
        endcase
        return k;
    endfunction

    // Bank slot for status and mask registers
    function automatic logic [SlotW-1:0] reg_slot_f(input logic [IdxW-1:0] idx);
        logic [SlotW-1:0] s;
        case (idx)
            5'd1, 5'd7:            s = 4'd1;
            5'd3, 5'd9:            s = 4'd2;
            5'd4, 5'd10:           s = 4'd3;
            5'd5, 5'd11:           s = 4'd4;
            5'd16, 5'd19:          s = 4'd5;
            5'd17, 5'd20:          s = 4'd6;
            5'd18, 5'd21:          s = 4'd7;
            5'd22, 5'd25:          s = 4'd8;
            5'd23, 5'd26:          s = 4'd9;
            5'd24, 5'd27:          s = 4'd10;
            5'd28, 5'd29:          s = 4'd11;
            default:               s = 4'd0;
        endcase
        return s;
    endfunction

endpackage

// File: hdl/isu_regbank.sv
module isu_regbank
    import isu_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      req_en,
    input  in_item_t  req,
    output out_item_t rsp
);

    logic [DataW-1:0] status_reg [BankDepth];
    logic [DataW-1:0] status_next [BankDepth];
    logic [DataW-1:0] mask_reg [BankDepth];
    logic [DataW-1:0] mask_next [BankDepth];
    logic [DataW-1:0] soft_reg, soft_next;
    logic [DataW-1:0] nmi_reg, nmi_next;
    logic [DataW-1:0] assign2_reg, assign2_next;
    logic [DataW-1:0] assign3_reg, assign3_next;

    reg_kind_t        kind;
    logic [SlotW-1:0] slot;
    logic [DataW-1:0] rd_val;

    assign kind = reg_kind_f(req.reg_index);
    assign slot = reg_slot_f(req.reg_index);

    // Decode the read value from current state
    always_comb begin
        case (kind)
            K_STATUS:  rd_val = status_reg[slot];
            K_MASK:    rd_val = mask_reg[slot];
            K_SOFT:    rd_val = soft_reg;
            K_NMI:     rd_val = nmi_reg;
            K_ASSIGN2: rd_val = assign2_reg;
            K_ASSIGN3: rd_val = assign3_reg;
            K_ONES:    rd_val = Full16;
            default:   rd_val = '0;
        endcase
    end

    // Apply the request to the register file
    always_comb begin
        status_next  = status_reg;
        mask_next    = mask_reg;
        soft_next    = soft_reg;
        nmi_next     = nmi_reg;
        assign2_next = assign2_reg;
        assign3_next = assign3_reg;
        if (req_en) begin
            case (req.req_type)
                REQ_WRITE: begin
                    case (kind)
                        K_STATUS:  status_next[slot] = status_reg[slot] & ~req.write_data;
                        K_MASK:    mask_next[slot] = req.write_data;
                        K_SOFT:    soft_next = req.write_data;
                        K_NMI:     nmi_next = req.write_data;
                        K_ASSIGN2: assign2_next = req.write_data;
                        K_ASSIGN3: assign3_next = req.write_data;
                        default:   ;
                    endcase
                end
                REQ_ASSERT: begin
                    status_next[SLOT_SYS1] = status_reg[SLOT_SYS1] | req.source_bits;
                end
                REQ_DEASSERT: begin
                    status_next[SLOT_SYS1] = status_reg[SLOT_SYS1] & ~req.source_bits;
                end
                default: ;
            endcase
        end
    end

    // Build the response from the post-update state
    always_comb begin
        rsp.read_data   = (req.req_type == REQ_READ) ? rd_val : '0;
        rsp.irq_pending = |((status_next[SLOT_SYS1] & mask_next[SLOT_SYS1]) |
                            (status_next[SLOT_SYS2] & mask_next[SLOT_SYS2]));
        rsp.bad_index   = ((req.req_type == REQ_READ) || (req.req_type == REQ_WRITE)) &&
                          (kind == K_UNMAPPED);
    end

    // Hold register state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < BankDepth; i++) begin
                status_reg[i] <= '0;
                mask_reg[i]   <= '0;
            end
            mask_reg[SLOT_GPIO_LO] <= Full16;
            mask_reg[SLOT_GPIO_HI] <= Full16;
            soft_reg    <= '0;
            nmi_reg     <= '0;
            assign2_reg <= '0;
            assign3_reg <= '0;
        end else begin
            status_reg  <= status_next;
            mask_reg    <= mask_next;
            soft_reg    <= soft_next;
            nmi_reg     <= nmi_next;
            assign2_reg <= assign2_next;
            assign3_reg <= assign3_next;
        end
    end

endmodule

// File: hdl/interrupt_status_mask_unit.sv
// Interrupt status and mask unit.
// Input channel s_*: one request item per handshake (read, write, assert or
// deassert of source bits in the first system status register, or a query).
// Result channel m_*: exactly one result item per request, in order, with the
// read value, the pending flag after the request, and the unmapped-index flag.
// Path: an item accepted on s_* lands in the input register; once the result
// register has room, it is applied to the register file and its result loads
// into the result register, which drives m_valid.
// Throughput: one item per cycle while m_ready stays high; the register file
// update and decode are combinational between the input and result registers.
// Stall: when m_ready is low the result register holds, the input register
// keeps the next item, and s_ready drops only once both are full.
// Reset (aresetn low, synchronous): status registers, soft request, NMI and
// assignment registers clear; masks clear except both GPIO masks, which set
// to all ones; both pipeline stages empty.
`include "assert_macros.svh"

module interrupt_status_mask_unit
    import isu_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    in_item_t  in_reg;
    logic      in_vld_reg, in_vld_next;
    out_item_t out_reg;
    logic      out_vld_reg, out_vld_next;
    out_item_t rsp;
    logic      advance;

    // Move the held item into the result register when there is room
    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;

    isu_regbank u_regbank (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req_en  (advance),
        .req     (in_reg),
        .rsp     (rsp)
    );

    // Next valid flags for both stages
    always_comb begin
        in_vld_next  = (s_valid && s_ready) || (in_vld_reg && !advance);
        out_vld_next = advance || (out_vld_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Capture payloads
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_item;
        end
        if (advance) begin
            out_reg <= rsp;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_item  = out_reg;

    `ISU_ASSERT_NXT(a_advance_fills, advance, out_vld_reg)
    `ISU_ASSERT_NXT(a_held_item_kept, in_vld_reg && !advance, in_vld_reg)
    `ISU_ASSERT_NXT(a_nonread_zero, advance && (in_reg.req_type != REQ_READ),
                    m_item.read_data == '0)
    `ISU_ASSERT_IMP(a_unmapped_reads_zero, out_vld_reg && out_reg.bad_index,
                    out_reg.read_data == '0)

endmodule

// File: tb/interrupt_status_mask_unit_tb.sv
`timescale 1ns / 1ps

module interrupt_status_mask_unit_tb;
    import isu_pkg::*;

    // Register numbers in read decoder order
    typedef enum logic [IdxW-1:0] {
        IX_SYS1_ST, IX_PIU_ST, IX_TMR_ST, IX_KIU_ST, IX_GPL_ST, IX_DSIU_ST,
        IX_SYS1_MK, IX_PIU_MK, IX_TMR_MK, IX_KIU_MK, IX_GPL_MK, IX_DSIU_MK,
        IX_NMI, IX_SOFT, IX_ASG2, IX_ASG3,
        IX_SYS2_ST, IX_GPH_ST, IX_FIR_ST, IX_SYS2_MK, IX_GPH_MK, IX_FIR_MK,
        IX_PCI_ST, IX_SCU_ST, IX_CSI_ST, IX_PCI_MK, IX_SCU_MK, IX_CSI_MK,
        IX_BCU_ST, IX_BCU_MK, IX_RSVD, IX_UNMAPPED
    } reg_idx_t;

    // Request codes with no defined meaning; the unit treats them as a query
    localparam logic [ReqW-1:0] REQ_SPARE5 = 3'd5;
    localparam logic [ReqW-1:0] REQ_SPARE6 = 3'd6;
    localparam logic [ReqW-1:0] REQ_SPARE7 = 3'd7;

    localparam int RandomItems = 1500;
    localparam int IdleLimit   = 2000;
    localparam int LongHold    = 120;
    localparam int EndDrain    = 10;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    interrupt_status_mask_unit uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // Shadow copy of the register file
    logic [DataW-1:0] stat_regs [BankDepth];
    logic [DataW-1:0] mask_regs [BankDepth];
    logic [DataW-1:0] soft_reg, nmi_reg, asg2_reg, asg3_reg;

    in_item_t  pending_reqs[$];
    bit        drain_first[$];
    out_item_t expected_results[$];

    logic s_fire = 1'b0;
    logic rx_long = 1'b0;
    logic long_hold_done = 1'b0;
    int   gap_left = 0, tx_calm = 0, hold_left = 0, rx_calm = 0;
    int   idle_cycles = 0, results_seen = 0, err_cnt = 0;
    int   n_reads = 0, n_writes = 0, n_src = 0, n_other = 0, n_pending = 0, n_bad = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic reg_kind_t reg_class(input logic [IdxW-1:0] idx);
        case (reg_idx_t'(idx))
            IX_SYS1_ST, IX_PIU_ST, IX_KIU_ST, IX_GPL_ST, IX_DSIU_ST, IX_SYS2_ST,
            IX_GPH_ST, IX_FIR_ST, IX_PCI_ST, IX_SCU_ST, IX_CSI_ST, IX_BCU_ST:
                return K_STATUS;
            IX_SYS1_MK, IX_PIU_MK, IX_KIU_MK, IX_GPL_MK, IX_DSIU_MK, IX_SYS2_MK,
            IX_GPH_MK, IX_FIR_MK, IX_PCI_MK, IX_SCU_MK, IX_CSI_MK, IX_BCU_MK:
                return K_MASK;
            IX_TMR_ST, IX_RSVD: return K_ZERO;
            IX_TMR_MK:          return K_ONES;
            IX_NMI:             return K_NMI;
            IX_SOFT:            return K_SOFT;
            IX_ASG2:            return K_ASSIGN2;
            IX_ASG3:            return K_ASSIGN3;
            default:            return K_UNMAPPED;
        endcase
    endfunction

    function automatic int bank_slot(input logic [IdxW-1:0] idx);
        case (reg_idx_t'(idx))
            IX_PIU_ST, IX_PIU_MK:   return 1;
            IX_KIU_ST, IX_KIU_MK:   return 2;
            IX_GPL_ST, IX_GPL_MK:   return int'(SLOT_GPIO_LO);
            IX_DSIU_ST, IX_DSIU_MK: return 4;
            IX_SYS2_ST, IX_SYS2_MK: return int'(SLOT_SYS2);
            IX_GPH_ST, IX_GPH_MK:   return int'(SLOT_GPIO_HI);
            IX_FIR_ST, IX_FIR_MK:   return 7;
            IX_PCI_ST, IX_PCI_MK:   return 8;
            IX_SCU_ST, IX_SCU_MK:   return 9;
            IX_CSI_ST, IX_CSI_MK:   return 10;
            IX_BCU_ST, IX_BCU_MK:   return 11;
            default:                return int'(SLOT_SYS1);
        endcase
    endfunction

    function automatic void clear_regs();
        for (int i = 0; i < BankDepth; i++) begin
            stat_regs[i] = '0;
            mask_regs[i] = '0;
        end
        mask_regs[SLOT_GPIO_LO] = Full16;
        mask_regs[SLOT_GPIO_HI] = Full16;
        soft_reg = '0;
        nmi_reg  = '0;
        asg2_reg = '0;
        asg3_reg = '0;
    endfunction

    // Apply one request to the shadow registers and form its result
    function automatic out_item_t apply_request(input in_item_t it);
        out_item_t res;
        reg_kind_t kind;
        int sl;
        res  = '0;
        kind = reg_class(it.reg_index);
        sl   = bank_slot(it.reg_index);
        case (it.req_type)
            REQ_READ: begin
                case (kind)
                    K_STATUS:  res.read_data = stat_regs[sl];
                    K_MASK:    res.read_data = mask_regs[sl];
                    K_SOFT:    res.read_data = soft_reg;
                    K_NMI:     res.read_data = nmi_reg;
                    K_ASSIGN2: res.read_data = asg2_reg;
                    K_ASSIGN3: res.read_data = asg3_reg;
                    K_ONES:    res.read_data = Full16;
                    default:   res.read_data = '0;
                endcase
                res.bad_index = (kind == K_UNMAPPED);
            end
            REQ_WRITE: begin
                case (kind)
                    K_STATUS:  stat_regs[sl] = stat_regs[sl] & ~it.write_data;
                    K_MASK:    mask_regs[sl] = it.write_data;
                    K_SOFT:    soft_reg = it.write_data;
                    K_NMI:     nmi_reg = it.write_data;
                    K_ASSIGN2: asg2_reg = it.write_data;
                    K_ASSIGN3: asg3_reg = it.write_data;
                    default:   ;
                endcase
                res.bad_index = (kind == K_UNMAPPED);
            end
            REQ_ASSERT:   stat_regs[SLOT_SYS1] = stat_regs[SLOT_SYS1] | it.source_bits;
            REQ_DEASSERT: stat_regs[SLOT_SYS1] = stat_regs[SLOT_SYS1] & ~it.source_bits;
            default:      ;
        endcase
        res.irq_pending = |((stat_regs[SLOT_SYS1] & mask_regs[SLOT_SYS1]) |
                            (stat_regs[SLOT_SYS2] & mask_regs[SLOT_SYS2]));
        return res;
    endfunction

    // Mostly short idle stretches, a few long ones
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [DataW-1:0] rand_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 20) return Full16;
        return DataW'($urandom);
    endfunction

    task automatic queue_req(input logic [ReqW-1:0] rq, input logic [IdxW-1:0] idx,
                             input logic [DataW-1:0] wd, input logic [DataW-1:0] src,
                             input bit drain);
        in_item_t it;
        it.req_type    = rq;
        it.reg_index   = idx;
        it.write_data  = wd;
        it.source_bits = src;
        pending_reqs.push_back(it);
        drain_first.push_back(drain);
    endtask

    // Fill the request queue (directed part first, random after), release reset, then drain and report
    initial begin : stim_proc
        int r;
        logic [ReqW-1:0] rq;
        logic [IdxW-1:0] idx;
        clear_regs();

        queue_req(REQ_READ, IX_GPL_MK, '0, '0, 1'b0);
        queue_req(REQ_READ, IX_GPH_MK, '0, '0, 1'b0);
        queue_req(REQ_READ, IX_TMR_MK, '0, '0, 1'b0);
        queue_req(REQ_WRITE, IX_TMR_MK, '0, Full16, 1'b0);
        queue_req(REQ_READ, IX_TMR_MK, Full16, '0, 1'b0);
        queue_req(REQ_WRITE, IX_TMR_ST, Full16, '0, 1'b0);
        queue_req(REQ_WRITE, IX_RSVD, Full16, '0, 1'b0);
        queue_req(REQ_READ, IX_RSVD, '0, Full16, 1'b0);
        queue_req(REQ_WRITE, IX_UNMAPPED, Full16, Full16, 1'b0);
        queue_req(REQ_READ, IX_UNMAPPED, '0, '0, 1'b0);
        queue_req(REQ_WRITE, IX_SYS1_MK, Full16, '0, 1'b0);
        // assert ignores index and write data
        queue_req(REQ_ASSERT, IX_UNMAPPED, Full16, Full16, 1'b0);
        queue_req(REQ_READ, IX_SYS1_ST, '0, '0, 1'b0);
        queue_req(REQ_DEASSERT, IX_SYS1_MK, Full16, 16'h00FF, 1'b0);
        // write-one-to-clear on the status register
        queue_req(REQ_WRITE, IX_SYS1_ST, 16'hFF00, '0, 1'b0);
        queue_req(REQ_READ, IX_SYS1_ST, '0, '0, 1'b0);
        queue_req(REQ_WRITE, IX_NMI, 16'hA5A5, '0, 1'b0);
        queue_req(REQ_READ, IX_NMI, '0, '0, 1'b0);
        queue_req(REQ_WRITE, IX_SOFT, 16'h5A5A, '0, 1'b0);
        queue_req(REQ_WRITE, IX_ASG2, Full16, '0, 1'b0);
        queue_req(REQ_WRITE, IX_ASG3, 16'h0001, '0, 1'b0);
        queue_req(REQ_QUERY, IX_SYS1_MK, Full16, Full16, 1'b0);
        queue_req(REQ_SPARE5, IX_SYS1_MK, '0, Full16, 1'b0);
        queue_req(REQ_SPARE6, IX_SYS1_ST, Full16, Full16, 1'b0);
        queue_req(REQ_SPARE7, IX_NMI, Full16, Full16, 1'b0);

        for (int i = 0; i < RandomItems; i++) begin
            r = $urandom_range(0, 99);
            if (r < 30)      rq = REQ_READ;
            else if (r < 60) rq = REQ_WRITE;
            else if (r < 75) rq = REQ_ASSERT;
            else if (r < 85) rq = REQ_DEASSERT;
            else if (r < 92) rq = REQ_QUERY;
            else begin
                case ($urandom_range(0, 2))
                    0:       rq = REQ_SPARE5;
                    1:       rq = REQ_SPARE6;
                    default: rq = REQ_SPARE7;
                endcase
            end
            // steer some accesses at the registers behind the pending flag
            r = $urandom_range(0, 99);
            if (r < 10)      idx = IX_SYS1_ST;
            else if (r < 20) idx = IX_SYS1_MK;
            else             idx = IdxW'($urandom);
            queue_req(rq, idx, rand_word(), rand_word(), (i == 0) || (i == 700) || (i == 1200));
        end

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (!(pending_reqs.size() == 0 && !s_valid && expected_results.size() == 0))
            @(negedge aclk);
        repeat (EndDrain) @(posedge aclk);
        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            err_cnt++;
        end

        $display("Run covered %0d reads, %0d writes, %0d source updates, %0d queries or spare codes",
                 n_reads, n_writes, n_src, n_other);
        $display("Results: %0d with interrupt pending, %0d unmapped accesses, %0d mismatches",
                 n_pending, n_bad, err_cnt);
        if (err_cnt == 0) begin
            $display("interrupt_status_mask_unit verification clean");
        end else begin
            $display("interrupt_status_mask_unit verification failed");
        end
        $finish;
    end

    // Sender: hold the item until accepted, then advance after a random gap
    always @(negedge aclk) begin : drive_proc
        logic     v;
        in_item_t nxt;
        v   = s_valid;
        nxt = s_item;
        if (!aresetn) begin
            v = 1'b0;
        end else if (!s_valid || s_fire) begin
            v = 1'b0;
            if (rx_long) gap_left = 0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_reqs.size() != 0 &&
                         !(drain_first[0] && expected_results.size() != 0)) begin
                nxt = pending_reqs.pop_front();
                void'(drain_first.pop_front());
                v = 1'b1;
                if (tx_calm > 0) tx_calm--;
                else if ($urandom_range(0, 99) < 2) tx_calm = $urandom_range(50, 150);
                else if ($urandom_range(0, 99) < 30) gap_left = idle_len();
            end
        end
        s_valid <= v;
        s_item  <= nxt;
    end

    // Receiver: random stalls, calm stretches, and one long hold-off
    always @(negedge aclk) begin : ready_proc
        logic rdy;
        if (!aresetn) begin
            rdy = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (!long_hold_done && results_seen >= 400) begin
            long_hold_done = 1'b1;
            rx_long = 1'b1;
            hold_left = LongHold - 1;
            rdy = 1'b0;
        end else begin
            rx_long = 1'b0;
            if (rx_calm > 0) begin
                rx_calm--;
                rdy = 1'b1;
            end else if ($urandom_range(0, 99) < 2) begin
                rx_calm = $urandom_range(50, 200);
                rdy = 1'b1;
            end else if ($urandom_range(0, 99) < 25) begin
                hold_left = idle_len() - 1;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
        end
        m_ready <= rdy;
    end

    // Check each result against the oldest expectation, then predict new items
    always @(posedge aclk) begin : check_proc
        out_item_t want;
        if (!aresetn) begin
            s_fire <= 1'b0;
        end else begin
            s_fire <= s_valid && s_ready;
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;

            if (m_valid && m_ready) begin
                results_seen++;
                if (m_item.irq_pending) n_pending++;
                if (m_item.bad_index) n_bad++;
                if (expected_results.size() == 0) begin
                    $error("result arrived with nothing expected");
                    err_cnt++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_item.read_data !== want.read_data) begin
                        $error("read_data: expected %h, got %h", want.read_data, m_item.read_data);
                        err_cnt++;
                    end
                    if (m_item.irq_pending !== want.irq_pending) begin
                        $error("irq_pending: expected %b, got %b",
                               want.irq_pending, m_item.irq_pending);
                        err_cnt++;
                    end
                    if (m_item.bad_index !== want.bad_index) begin
                        $error("bad_index: expected %b, got %b", want.bad_index, m_item.bad_index);
                        err_cnt++;
                    end
                end
            end

            if (s_valid && s_ready) begin
                expected_results.push_back(apply_request(s_item));
                case (s_item.req_type)
                    REQ_READ:                 n_reads++;
                    REQ_WRITE:                n_writes++;
                    REQ_ASSERT, REQ_DEASSERT: n_src++;
                    default:                  n_other++;
                endcase
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial begin : watchdog_proc
        while (idle_cycles < IdleLimit) @(negedge aclk);
        $display("interrupt_status_mask_unit verification failed");
        $finish;
    end

endmodule
